// ===== design/button_menu_controller_macros.svh =====
// Assertion macros shared by the button menu controller RTL.
// No dependencies; included by the files that carry assertions.
`ifndef BUTTON_MENU_CONTROLLER_MACROS_SVH
`define BUTTON_MENU_CONTROLLER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define BMC_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("button menu controller: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define BMC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("button menu controller: next-cycle check failed");

`endif

// ===== design/bmc_pkg.sv =====
// Shared types and constants of the button menu controller.
// No dependencies; used by bmc_step and button_menu_controller.
package bmc_pkg;

    localparam logic [7:0] PRESS_LIMIT_RST = 8'd40;
    localparam logic [6:0] TRACK_TOP_RST   = 7'd99;
    localparam logic [5:0] MAX_VOLUME_RST  = 6'd30;
    localparam logic [6:0] TRACK_RST       = 7'd1;
    localparam logic [5:0] VOLUME_RST      = 6'd20;
    localparam logic [2:0] LEVELS_RST      = 3'b111;

    typedef enum logic [1:0] {
        PLAYER_START      = 2'd0,
        PLAYER_HALT       = 2'd1,
        PLAYER_SET_VOLUME = 2'd2
    } cmd_kind_t;

    typedef enum logic [1:0] {
        CFG_PRESS_LIMIT = 2'd0,
        CFG_TRACK_TOP   = 2'd1,
        CFG_MAX_VOLUME  = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [7:0] press_limit;
        logic [6:0] track_top;
        logic [5:0] max_volume;
    } bmc_cfg_t;

    typedef struct packed {
        logic       prev_level;
        logic       next_level;
        logic       play_level;
        logic       player_playing;
    } bmc_tick_t;

    typedef struct packed {
        logic [2:0]      last_levels;
        logic [1:0][7:0] hold_count;
        logic [1:0]      hold_done;
        logic            mode;
        logic [6:0]      track;
        logic [5:0]      volume;
    } bmc_state_t;

    typedef struct packed {
        logic       cmd_valid;
        cmd_kind_t  cmd_kind;
        logic [6:0] cmd_arg;
        logic       volume_mode;
        logic [6:0] track_now;
        logic [5:0] volume_now;
    } bmc_result_t;

endpackage

// ===== design/bmc_step.sv =====
// Next-state and result logic for one poll tick of the button menu.
// Depends on bmc_pkg.
module bmc_step (
    input  bmc_pkg::bmc_cfg_t    cfg,
    input  bmc_pkg::bmc_state_t  state_i,
    input  bmc_pkg::bmc_tick_t   tick,
    output bmc_pkg::bmc_state_t  state_o,
    output bmc_pkg::bmc_result_t result
);

    logic [2:0] cur;
    logic [2:0] press_edge;

    assign cur        = {tick.play_level, tick.next_level, tick.prev_level};
    assign press_edge = ~cur & state_i.last_levels;

    always_comb begin
        state_o          = state_i;
        result.cmd_valid = 1'b0;
        result.cmd_kind  = bmc_pkg::PLAYER_START;
        result.cmd_arg   = 7'd0;
        if (!state_i.mode) begin
            for (int i = 0; i < 2; i++) begin
                if (!cur[i]) begin
                    if (state_o.hold_count[i] < cfg.press_limit) begin
                        state_o.hold_count[i] = state_o.hold_count[i] + 8'd1;
                    end
                    if (state_o.hold_count[i] >= cfg.press_limit && !state_o.hold_done[i]) begin
                        state_o.hold_done[i] = 1'b1;
                        state_o.mode         = 1'b1;
                    end
                end else begin
                    state_o.hold_count[i] = 8'd0;
                    state_o.hold_done[i]  = 1'b0;
                end
            end
            if (press_edge[0] && state_o.hold_count[0] < cfg.press_limit) begin
                state_o.track = (state_o.track <= 7'd1) ? cfg.track_top
                                                        : state_o.track - 7'd1;
            end
            if (press_edge[1] && state_o.hold_count[1] < cfg.press_limit) begin
                state_o.track = (state_o.track >= cfg.track_top) ? 7'd1
                                                                 : state_o.track + 7'd1;
            end
            if (press_edge[2]) begin
                result.cmd_valid = 1'b1;
                if (tick.player_playing) begin
                    result.cmd_kind = bmc_pkg::PLAYER_HALT;
                end else begin
                    result.cmd_kind = bmc_pkg::PLAYER_START;
                    result.cmd_arg  = state_o.track;
                end
            end
        end else begin
            state_o.hold_count = '0;
            state_o.hold_done  = 2'b00;
            if (press_edge[0]) begin
                state_o.volume = (state_o.volume > 6'd0) ? state_o.volume - 6'd1 : 6'd0;
            end
            if (press_edge[1]) begin
                state_o.volume = (state_o.volume < cfg.max_volume) ? state_o.volume + 6'd1
                                                                   : cfg.max_volume;
            end
            if (press_edge[0] || press_edge[1]) begin
                result.cmd_valid = 1'b1;
                result.cmd_kind  = bmc_pkg::PLAYER_SET_VOLUME;
                result.cmd_arg   = {1'b0, state_o.volume};
            end
            if (press_edge[2]) begin
                state_o.mode = 1'b0;
            end
        end
        state_o.last_levels = cur;
        result.volume_mode  = state_o.mode;
        result.track_now    = state_o.track;
        result.volume_now   = state_o.volume;
    end

endmodule

// ===== design/button_menu_controller.sv =====
// Top level of the button menu controller: menu state, configuration and output register.
// Depends on bmc_pkg, bmc_step and button_menu_controller_macros.svh.
//
// Each input beat is one poll tick: s_tdata carries the three active-low button
// levels and the player's playing flag. Every accepted beat yields exactly one
// result beat on the m_ side, with an optional player command in m_tuser and its
// argument and the menu status (mode, track, volume) in m_tdata.
// The result of a beat accepted at one edge is registered and offered from the
// following cycle on. Throughput is one beat per cycle while the output is not stalled;
// the state update and the result are computed together in combinational logic.
// s_tready stays high while the output register is empty or being emptied, so
// a stalled receiver holds the pending result and blocks new ticks only then.
// Reset (synchronous, aresetn low) restores track mode, track one, volume twenty,
// released buttons, cleared hold counters and the default registers (hold 40 ticks,
// max track 99, max volume 30), and empties the output. The user must write registers via
// cfg_wr_en, cfg_index and cfg_data only while idle; the block does not enforce this.
`include "button_menu_controller_macros.svh"

module button_menu_controller (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // prev_level, next_level, play_level, player_playing
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // cmd_arg, volume_mode, track_now, volume_now
    output logic [2:0]  m_tuser,   // cmd_valid, cmd_kind
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    bmc_pkg::bmc_cfg_t    cfg_reg;
    bmc_pkg::bmc_state_t  state_reg;
    bmc_pkg::bmc_state_t  state_next;
    bmc_pkg::bmc_tick_t   tick;
    bmc_pkg::bmc_result_t result_next;
    bmc_pkg::bmc_result_t result_reg;
    logic                 m_valid_reg;
    logic                 s_fire;

    assign s_tready = !m_valid_reg || m_tready;
    assign s_fire   = s_tvalid && s_tready;

    assign tick.prev_level     = s_tdata[0];
    assign tick.next_level     = s_tdata[1];
    assign tick.play_level     = s_tdata[2];
    assign tick.player_playing = s_tdata[3];

    bmc_step u_step (
        .cfg     (cfg_reg),
        .state_i (state_reg),
        .tick    (tick),
        .state_o (state_next),
        .result  (result_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.press_limit <= bmc_pkg::PRESS_LIMIT_RST;
            cfg_reg.track_top   <= bmc_pkg::TRACK_TOP_RST;
            cfg_reg.max_volume  <= bmc_pkg::MAX_VOLUME_RST;
        end else if (cfg_wr_en) begin
            case (bmc_pkg::cfg_index_t'(cfg_index))
                bmc_pkg::CFG_PRESS_LIMIT: cfg_reg.press_limit <= cfg_data;
                bmc_pkg::CFG_TRACK_TOP:   cfg_reg.track_top   <= cfg_data[6:0];
                bmc_pkg::CFG_MAX_VOLUME:  cfg_reg.max_volume  <= cfg_data[5:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.last_levels <= bmc_pkg::LEVELS_RST;
            state_reg.hold_count  <= '0;
            state_reg.hold_done   <= 2'b00;
            state_reg.mode        <= 1'b0;
            state_reg.track       <= bmc_pkg::TRACK_RST;
            state_reg.volume      <= bmc_pkg::VOLUME_RST;
            m_valid_reg           <= 1'b0;
        end else begin
            if (s_fire) begin
                state_reg <= state_next;
            end
            if (s_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            result_reg <= result_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = {result_reg.cmd_kind, result_reg.cmd_valid};
    assign m_tdata  = {3'b000, result_reg.volume_now, result_reg.track_now,
                       result_reg.volume_mode, result_reg.cmd_arg};

    `BMC_ASSERT_NOW(a_kind_legal, aclk, aresetn, m_valid_reg,
        result_reg.cmd_kind != 2'd3)
    `BMC_ASSERT_NEXT(a_track_mode_keeps_volume, aclk, aresetn, s_fire && !state_reg.mode,
        $stable(state_reg.volume))
    `BMC_ASSERT_NEXT(a_volume_mode_keeps_track, aclk, aresetn, s_fire && state_reg.mode,
        $stable(state_reg.track))
    `BMC_ASSERT_NEXT(a_volume_mode_clears_hold, aclk, aresetn, s_fire && state_reg.mode,
        state_reg.hold_count == '0 && state_reg.hold_done == 2'b00)
    `BMC_ASSERT_NEXT(a_idle_keeps_state, aclk, aresetn, !s_fire,
        $stable(state_reg))

endmodule

// ===== bench/button_menu_controller_tb.sv =====
// Self-checking testbench for the button menu controller: drives poll-tick beats,
// predicts every result beat and compares it field by field. Depends on bmc_pkg
// and the button_menu_controller RTL.
`timescale 1ns / 100ps

module button_menu_controller_tb;

    localparam int WATCHDOG_LIMIT = 2000;

    localparam bit [2:0] RELEASED  = 3'b111;
    localparam bit [2:0] PREV_DOWN = 3'b110;
    localparam bit [2:0] NEXT_DOWN = 3'b101;
    localparam bit [2:0] PLAY_DOWN = 3'b011;
    localparam bit [2:0] BOTH_DOWN = 3'b100;
    localparam bit [2:0] ALL_DOWN  = 3'b000;

    class menu_scoreboard;
        logic [7:0]           press_limit;
        logic [6:0]           track_top;
        logic [5:0]           max_volume;
        logic [2:0]           last_levels;
        logic [7:0]           hold_count[2];
        logic                 hold_done[2];
        logic                 mode;
        logic [6:0]           track;
        logic [5:0]           volume;
        bmc_pkg::bmc_result_t pending_results[$];
        int                   errors;

        function new();
            press_limit = bmc_pkg::PRESS_LIMIT_RST;
            track_top   = bmc_pkg::TRACK_TOP_RST;
            max_volume  = bmc_pkg::MAX_VOLUME_RST;
            last_levels = bmc_pkg::LEVELS_RST;
            hold_count  = '{8'd0, 8'd0};
            hold_done   = '{1'b0, 1'b0};
            mode        = 1'b0;
            track       = bmc_pkg::TRACK_RST;
            volume      = bmc_pkg::VOLUME_RST;
            errors      = 0;
        endfunction

        function void set_reg(bmc_pkg::cfg_index_t idx, logic [7:0] val);
            case (idx)
                bmc_pkg::CFG_PRESS_LIMIT: press_limit = val;
                bmc_pkg::CFG_TRACK_TOP:   track_top   = val[6:0];
                bmc_pkg::CFG_MAX_VOLUME:  max_volume  = val[5:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        function void note_tick(bmc_pkg::bmc_tick_t t);
            logic [2:0]           cur;
            logic [2:0]           fell;
            bmc_pkg::bmc_result_t r;
            cur  = {t.play_level, t.next_level, t.prev_level};
            fell = ~cur & last_levels;
            r    = '0;
            if (!mode) begin
                for (int i = 0; i < 2; i++) begin
                    if (!cur[i]) begin
                        if (hold_count[i] < press_limit) hold_count[i]++;
                        if (hold_count[i] >= press_limit && !hold_done[i]) begin
                            hold_done[i] = 1'b1;
                            mode = 1'b1;
                        end
                    end else begin
                        hold_count[i] = 8'd0;
                        hold_done[i]  = 1'b0;
                    end
                end
                if (fell[0] && hold_count[0] < press_limit)
                    track = (track <= 7'd1) ? track_top : track - 7'd1;
                if (fell[1] && hold_count[1] < press_limit)
                    track = (track >= track_top) ? 7'd1 : track + 7'd1;
                if (fell[2]) begin
                    r.cmd_valid = 1'b1;
                    if (t.player_playing) begin
                        r.cmd_kind = bmc_pkg::PLAYER_HALT;
                    end else begin
                        r.cmd_kind = bmc_pkg::PLAYER_START;
                        r.cmd_arg  = track;
                    end
                end
            end else begin
                hold_count = '{8'd0, 8'd0};
                hold_done  = '{1'b0, 1'b0};
                if (fell[0]) begin
                    volume      = (volume > 6'd0) ? volume - 6'd1 : 6'd0;
                    r.cmd_valid = 1'b1;
                    r.cmd_kind  = bmc_pkg::PLAYER_SET_VOLUME;
                    r.cmd_arg   = {1'b0, volume};
                end
                if (fell[1]) begin
                    volume      = (volume < max_volume) ? volume + 6'd1 : max_volume;
                    r.cmd_valid = 1'b1;
                    r.cmd_kind  = bmc_pkg::PLAYER_SET_VOLUME;
                    r.cmd_arg   = {1'b0, volume};
                end
                if (fell[2]) mode = 1'b0;
            end
            last_levels   = cur;
            r.volume_mode = mode;
            r.track_now   = track;
            r.volume_now  = volume;
            pending_results.push_back(r);
        endfunction

        function void compare_field(string name, int want, int got);
            if (want != got) begin
                $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic [23:0] data, logic [2:0] user);
            bmc_pkg::bmc_result_t r;
            if (pending_results.size() == 0) begin
                $display("%0t: result beat expected none, actual tdata %h tuser %h",
                         $time, data, user);
                errors++;
                return;
            end
            r = pending_results.pop_front();
            compare_field("cmd_valid", r.cmd_valid, user[0]);
            compare_field("cmd_kind", r.cmd_kind, user[2:1]);
            compare_field("cmd_arg", r.cmd_arg, data[6:0]);
            compare_field("volume_mode", r.volume_mode, data[7]);
            compare_field("track_now", r.track_now, data[14:8]);
            compare_field("volume_now", r.volume_now, data[20:15]);
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        cfg_wr_en;
    logic [1:0]  cfg_index;
    logic [7:0]  cfg_data;

    menu_scoreboard menu_sb = new();
    int             cur_hold = int'(bmc_pkg::PRESS_LIMIT_RST);
    int             sent_ticks = 0;
    bit             quiet = 1'b0;
    int             idle_cycles = 0;

    button_menu_controller dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial aclk = 1'b0;
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // raw holds {player_playing, play_level, next_level, prev_level}.
    task automatic send_tick(bit [3:0] raw);
        int                 gap;
        bmc_pkg::bmc_tick_t t;
        gap = pick_gap();
        t.prev_level     = raw[0];
        t.next_level     = raw[1];
        t.play_level     = raw[2];
        t.player_playing = raw[3];
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, raw};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        menu_sb.note_tick(t);
        sent_ticks++;
    endtask

    task automatic hold_for(bit [2:0] lv, int n);
        bit pl;
        for (int k = 0; k < n; k++) begin
            pl = 1'($urandom_range(0, 1));
            send_tick({pl, lv});
        end
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (menu_sb.pending() != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    task automatic set_menu_regs(bit [7:0] hold, bit [6:0] top_track, bit [5:0] top_volume);
        cfg_wr_en <= 1'b1;
        cfg_index <= bmc_pkg::CFG_PRESS_LIMIT;
        cfg_data  <= hold;
        @(posedge aclk);
        cfg_index <= bmc_pkg::CFG_TRACK_TOP;
        cfg_data  <= {1'b0, top_track};
        @(posedge aclk);
        cfg_index <= bmc_pkg::CFG_MAX_VOLUME;
        cfg_data  <= {2'b00, top_volume};
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        menu_sb.set_reg(bmc_pkg::CFG_PRESS_LIMIT, hold);
        menu_sb.set_reg(bmc_pkg::CFG_TRACK_TOP, {1'b0, top_track});
        menu_sb.set_reg(bmc_pkg::CFG_MAX_VOLUME, {2'b00, top_volume});
        cur_hold = int'(hold);
    endtask

    // One button gesture; pick selects the kind, 30..44 is a full hold.
    task automatic gesture(int pick);
        int       tap_max;
        int       n;
        bit [2:0] btn;
        bit [3:0] raw;
        tap_max = (cur_hold > 1) ? ((cur_hold - 1 < 12) ? cur_hold - 1 : 12) : 1;
        btn = $urandom_range(0, 1) ? PREV_DOWN : NEXT_DOWN;
        if (pick < 30) begin
            hold_for(btn, $urandom_range(1, tap_max));
        end else if (pick < 45) begin
            hold_for(btn, cur_hold + $urandom_range(0, 3) + (cur_hold == 0));
        end else if (pick < 65) begin
            hold_for(PLAY_DOWN, $urandom_range(1, 3));
        end else if (pick < 75) begin
            n = $urandom_range(0, 1) ? $urandom_range(1, tap_max) : cur_hold + 1;
            hold_for(BOTH_DOWN, n);
        end else if (pick < 87) begin
            hold_for(btn, $urandom_range(1, tap_max));
            hold_for(BOTH_DOWN, $urandom_range(1, 3));
            hold_for(btn ^ 3'b011, $urandom_range(1, 2));
        end else begin
            n = $urandom_range(1, 4);
            for (int k = 0; k < n; k++) begin
                raw = 4'($urandom_range(0, 15));
                send_tick(raw);
            end
        end
        hold_for(RELEASED, $urandom_range(1, 2));
    endtask

    initial begin : result_sink
        int gap;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            gap = pick_gap();
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            menu_sb.check_result(m_tdata, m_tuser);
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("button_menu_controller: mismatch");
                $finish;
            end
        end
    end

    initial begin : tick_source
        int start;
        int target;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = 8'h00;
        cfg_wr_en = 1'b0;
        cfg_index = bmc_pkg::CFG_PRESS_LIMIT;
        cfg_data  = 8'h00;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset values: play and stop, track stepping and wrapping both ways.
        send_tick({1'b0, RELEASED});
        send_tick({1'b0, PLAY_DOWN});
        send_tick({1'b1, RELEASED});
        send_tick({1'b1, PLAY_DOWN});
        send_tick({1'b0, RELEASED});
        send_tick({1'b0, NEXT_DOWN});
        send_tick({1'b0, RELEASED});
        send_tick({1'b0, PREV_DOWN});
        send_tick({1'b0, RELEASED});
        send_tick({1'b0, PREV_DOWN});
        send_tick({1'b0, RELEASED});
        send_tick({1'b0, NEXT_DOWN});
        send_tick({1'b1, ALL_DOWN});
        send_tick({1'b0, RELEASED});
        wait_idle();

        // A one-tick hold enters volume mode without stepping the track.
        set_menu_regs(8'd1, 7'd127, 6'd63);
        send_tick({1'b0, NEXT_DOWN});
        send_tick({1'b0, RELEASED});
        send_tick({1'b0, NEXT_DOWN});
        send_tick({1'b0, RELEASED});
        send_tick({1'b0, BOTH_DOWN});
        send_tick({1'b0, RELEASED});
        send_tick({1'b0, PLAY_DOWN});
        send_tick({1'b0, RELEASED});
        wait_idle();

        // Zero hold time and volume above its new ceiling.
        set_menu_regs(8'd0, 7'd0, 6'd0);
        send_tick({1'b0, PREV_DOWN});
        send_tick({1'b0, RELEASED});
        send_tick({1'b0, NEXT_DOWN});
        send_tick({1'b1, PLAY_DOWN});
        send_tick({1'b0, RELEASED});
        wait_idle();

        for (int p = 0; p < 10; p++) begin
            target = 48;
            quiet  = (p == 2 || p == 7);
            case (p)
                0: set_menu_regs(8'd2, 7'd127, 6'd63);
                1: set_menu_regs(8'd3, 7'd4, 6'd0);
                2: set_menu_regs(8'd1, 7'd1, 6'd63);
                3: set_menu_regs(8'd0, 7'd0, 6'd5);
                4: set_menu_regs(8'd3, 7'd0, 6'd30);
                5: begin
                    set_menu_regs(8'd255, 7'd99, 6'd30);
                    target = 256;
                end
                default: set_menu_regs(8'($urandom_range(1, 8)), 7'($urandom_range(1, 127)),
                                       6'($urandom_range(0, 63)));
            endcase
            start = sent_ticks;
            gesture(40);
            while (sent_ticks - start < target) gesture($urandom_range(0, 99));
            wait_idle();
        end

        if (menu_sb.errors == 0 && menu_sb.pending() == 0) begin
            $display("button_menu_controller: match");
        end else begin
            $display("button_menu_controller: mismatch");
        end
        $finish;
    end

endmodule
